// File: rtl/core/bms_pkg.sv
// Package for the bounded message serializer.
// Holds operation and status codes, field widths and the encoder-to-serializer record.
// No dependencies.
package bms_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 16;
    localparam int unsigned MAX_BYTES             = 5;
    localparam int unsigned COUNT_BITS            = 3;
    localparam int unsigned OFFSET_BITS           = 16;
    localparam int unsigned CAPACITY_BITS         = 16;
    localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 16'hffff;

    localparam logic [7:0]  MORE_FLAG  = 8'h80;
    localparam logic [6:0]  LOW7       = 7'h7f;
    localparam logic [31:0] P16_LIMIT  = 32'h0000_8000;
    localparam int unsigned GROUP_BITS = 7;

    typedef enum logic [2:0] {
        OP_BYTE     = 3'd0,
        OP_WORD16   = 3'd1,
        OP_WORD32   = 3'd2,
        OP_PACKED16 = 3'd3,
        OP_PACKED32 = 3'd4,
        OP_SET_POS  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BOUNDS    = 2'd1,
        ST_TOO_LARGE = 2'd2
    } status_t;

    typedef struct packed {
        logic                                valid;
        logic [MAX_BYTES-1:0][7:0]           bytes;
        logic [COUNT_BITS-1:0]               count;
        logic [OFFSET_BITS-1:0]              offset;
        status_t                             status;
    } load_t;

endpackage

// File: rtl/core/bms_encoder.sv
// Operation decoder, bound check and byte encoder of the serializer.
// Depends on bms_pkg.
module bms_encoder
    import bms_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic [2:0]               operation,
    input  logic [31:0]              value,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [CAPACITY_BITS-1:0] capacity,
    output load_t                    load,
    output logic [POSITION_BITS-1:0] new_position
);

    localparam int unsigned Wide = 34;
    localparam logic [Wide-1:0] PosMax = (Wide'(1) << POSITION_BITS) - Wide'(1);

    logic [Wide-1:0]           pos_w;
    logic [Wide-1:0]           cap_w;
    logic [Wide-1:0]           limit;
    logic [Wide-1:0]           value_w;
    logic [35:0]               v36;
    logic [COUNT_BITS-1:0]     n;
    logic [MAX_BYTES-1:0][7:0] data;
    logic [MAX_BYTES-1:0][7:0] packed_bytes;
    logic                      fits;
    logic                      known;

    always_comb
    begin
        pos_w   = Wide'(position);
        cap_w   = Wide'(capacity);
        limit   = (cap_w < PosMax) ? cap_w : PosMax;
        value_w = Wide'(value);
        v36     = {4'b0, value};

        if (value < 32'h0000_0080)
            n = 3'd1;
        else if (value < 32'h0000_4000)
            n = 3'd2;
        else if (value < 32'h0020_0000)
            n = 3'd3;
        else if (value < 32'h1000_0000)
            n = 3'd4;
        else
            n = 3'd5;

        for (int k = 0; k < MAX_BYTES; k++)
        begin
            if (COUNT_BITS'(k) < n - 3'd1)
                packed_bytes[k] = MORE_FLAG | {1'b0, v36[k*GROUP_BITS +: 7] & LOW7};
            else if (COUNT_BITS'(k) == n - 3'd1)
                packed_bytes[k] = v36[k*GROUP_BITS +: 8];
            else
                packed_bytes[k] = 8'h00;
        end

        known = 1'b1;
        data  = '0;
        unique case (op_t'(operation))
            OP_BYTE:
            begin
                data[0] = value[7:0];
                n       = 3'd1;
            end
            OP_WORD16:
            begin
                data[0] = value[7:0];
                data[1] = value[15:8];
                n       = 3'd2;
            end
            OP_WORD32:
            begin
                data[3:0] = value;
                n         = 3'd4;
            end
            OP_PACKED16:
            begin
                if (value < 32'h0000_0080)
                begin
                    data[0] = value[7:0];
                    n       = 3'd1;
                end
                else
                begin
                    data[0] = MORE_FLAG | {1'b0, value[6:0]};
                    data[1] = value[14:7];
                    n       = 3'd2;
                end
            end
            OP_PACKED32:
            begin
                data = packed_bytes;
            end
            OP_SET_POS:
            begin
                n = 3'd1;
            end
            default:
            begin
                known = 1'b0;
                n     = 3'd1;
            end
        endcase

        fits = (pos_w + Wide'(n)) <= limit;

        load.valid   = known;
        load.bytes   = data;
        load.count   = n;
        load.offset  = OFFSET_BITS'(position);
        load.status  = ST_OK;
        new_position = position;

        if (op_t'(operation) == OP_SET_POS)
        begin
            load.bytes = '0;
            load.count = 3'd1;
            if (value_w <= limit)
            begin
                new_position = POSITION_BITS'(value_w);
                load.offset  = OFFSET_BITS'(value_w);
            end
            else
                load.status = ST_BOUNDS;
        end
        else if (op_t'(operation) == OP_PACKED16 && value >= P16_LIMIT)
        begin
            load.bytes  = '0;
            load.count  = 3'd1;
            load.status = ST_TOO_LARGE;
        end
        else if (!fits)
        begin
            load.bytes  = '0;
            load.count  = 3'd1;
            load.status = ST_BOUNDS;
        end
        else if (known)
            new_position = POSITION_BITS'(pos_w + Wide'(n));
    end

endmodule

// File: rtl/core/bms_serializer.sv
// Output stage: holds the encoded bytes of one transaction and emits one per cycle while out_ready is high.
// Depends on bms_pkg.
module bms_serializer
    import bms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_en,
    input  load_t                  load,
    output logic                   load_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic [OFFSET_BITS-1:0] byte_offset,
    output logic                   last,
    output logic [1:0]             status
);

    logic                      valid_reg;
    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [COUNT_BITS-1:0]     remaining_reg;
    logic [OFFSET_BITS-1:0]    offset_reg;
    status_t                   status_reg;
    logic                      advance;

    assign advance    = valid_reg && out_ready;
    assign last       = remaining_reg == 3'd1;
    assign load_ready = !valid_reg || (advance && last);
    assign out_valid  = valid_reg;
    assign out_byte   = bytes_reg[0];
    assign byte_offset = offset_reg;
    assign status     = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            remaining_reg <= '0;
        end
        else if (load_en)
        begin
            valid_reg     <= load.valid;
            remaining_reg <= load.count;
        end
        else if (advance)
        begin
            valid_reg     <= !last;
            remaining_reg <= remaining_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            bytes_reg  <= load.bytes;
            offset_reg <= load.offset;
            status_reg <= load.status;
        end
        else if (advance)
        begin
            bytes_reg  <= {8'h00, bytes_reg[MAX_BYTES-1:1]};
            offset_reg <= offset_reg + 16'd1;
        end
    end

`ifndef SYNTHESIS
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> remaining_reg != 3'd0)
        else $error("active transaction with no bytes left");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != ST_OK) |-> last)
        else $error("status result not marked last");
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last) |=> (valid_reg && offset_reg == $past(offset_reg) + 16'd1))
        else $error("offset did not advance within transaction");
`endif

endmodule

// File: rtl/core/bounded_message_serializer_top.sv
// Bounded message serializer top level: position and capacity registers, encoder, output stage.
// Latency: the first result of a transaction is valid the cycle after it is accepted.
// Throughput: an item of n result bytes (1 to 5) holds the input until the one-byte-per-cycle
// output stage takes its last byte; single-result items flow at one per cycle while out_ready is high.
// Reset: write position clears to 0, buffer capacity returns to 65535, output empties.
// Depends on bms_pkg, bms_encoder, bms_serializer.
module bounded_message_serializer_top
    import bms_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CAPACITY_BITS-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               operation,
    input  logic [31:0]              value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_byte,
    output logic [OFFSET_BITS-1:0]   byte_offset,
    output logic                     last,
    output logic [1:0]               status
);

    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    logic [CAPACITY_BITS-1:0] capacity_reg;
    load_t                    load;
    logic                     accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            if (accept)
                position_reg <= position_next;
            if (cfg_we)
                capacity_reg <= cfg_wdata;
        end
    end

    bms_encoder #(
        .POSITION_BITS (POSITION_BITS)
    ) u_encoder (
        .operation    (operation),
        .value        (value),
        .position     (position_reg),
        .capacity     (capacity_reg),
        .load         (load),
        .new_position (position_next)
    );

    bms_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (accept),
        .load        (load),
        .load_ready  (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_offset (byte_offset),
        .last        (last),
        .status      (status)
    );

endmodule

// File: tb/sv/bounded_message_serializer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_message_serializer_top: a directed table, then random
// phases across capacity settings and idle patterns, checked against an in-bench encoder.
// Depends on bms_pkg and the bounded_message_serializer_top RTL.
module bounded_message_serializer_top_tb;
    import bms_pkg::*;

    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         N_DIRECTED    = 26;
    localparam int         MAX_REPORTS   = 10;
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] offset;
        logic        last;
        status_t     status;
    } serial_byte_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [31:0]  value;
        logic         typed;
        serial_byte_t known;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CAPACITY_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic [2:0]               operation = '0;
    logic [31:0]              value     = '0;
    logic                     out_ready = 1'b0;
    wire                      in_ready;
    wire                      out_valid;
    wire  [7:0]               out_byte;
    wire  [OFFSET_BITS-1:0]   byte_offset;
    wire                      last;
    wire  [1:0]               status;

    logic         cur_typed     = 1'b0;
    serial_byte_t cur_known     = '0;
    logic         hold_kick     = 1'b0;
    int           hold_left     = 0;
    int           out_stall_pct = 0;
    int           in_idle_pct   = 0;

    logic [15:0]  model_pos = '0;
    logic [15:0]  model_cap = CAPACITY_RESET;
    serial_byte_t fresh_q[$];
    serial_byte_t pending_q[$];

    int mismatch_count  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int bounds_seen     = 0;
    int too_large_seen  = 0;
    int capacity_writes = 0;

    bounded_message_serializer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_offset(byte_offset),
        .last       (last),
        .status     (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Encode one transaction into fresh_q and advance or set the modeled write position.
    function automatic int encode_item(input logic [2:0] op, input logic [31:0] v);
        logic [7:0]  enc [MAX_BYTES];
        logic [31:0] rest;
        int          n;
        n = 0;
        rest = v;
        for (int k = 0; k < MAX_BYTES; k++)
            enc[k] = '0;
        case (op)
            OP_BYTE:
            begin
                enc[0] = v[7:0];
                n = 1;
            end
            OP_WORD16:
            begin
                enc[0] = v[7:0];
                enc[1] = v[15:8];
                n = 2;
            end
            OP_WORD32:
            begin
                for (int k = 0; k < 4; k++)
                    enc[k] = v[8*k +: 8];
                n = 4;
            end
            OP_PACKED16:
            begin
                if (v >= P16_LIMIT)
                begin
                    fresh_q.push_back(serial_byte_t'{8'h00, model_pos, 1'b1, ST_TOO_LARGE});
                    return 1;
                end
                if (v < MORE_FLAG)
                begin
                    enc[0] = v[7:0];
                    n = 1;
                end
                else
                begin
                    enc[0] = MORE_FLAG | {1'b0, v[6:0] & LOW7};
                    enc[1] = v[14:7];
                    n = 2;
                end
            end
            OP_PACKED32:
            begin
                while (rest >= MORE_FLAG && n < 4)
                begin
                    enc[n] = MORE_FLAG | {1'b0, rest[6:0] & LOW7};
                    rest = rest >> GROUP_BITS;
                    n++;
                end
                enc[n] = rest[7:0];
                n++;
            end
            OP_SET_POS:
            begin
                if (v <= {16'h0000, model_cap})
                begin
                    model_pos = v[15:0];
                    fresh_q.push_back(serial_byte_t'{8'h00, model_pos, 1'b1, ST_OK});
                end
                else
                    fresh_q.push_back(serial_byte_t'{8'h00, model_pos, 1'b1, ST_BOUNDS});
                return 1;
            end
            default:
                return 0;
        endcase
        if (int'(model_pos) + n > int'(model_cap))
        begin
            fresh_q.push_back(serial_byte_t'{8'h00, model_pos, 1'b1, ST_BOUNDS});
            return 1;
        end
        for (int k = 0; k < n; k++)
        begin
            fresh_q.push_back(serial_byte_t'{enc[k], model_pos, (k == n - 1), ST_OK});
            model_pos = model_pos + 16'd1;
        end
        return n;
    endfunction

    function automatic void flag_mismatch(input string what, input serial_byte_t want,
                                          input serial_byte_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected byte %02h offset %0d last %0b status %0d,",
                     $realtime, what, want.data, want.offset, want.last, want.status,
                     " got byte %02h offset %0d last %0b status %0d",
                     got.data, got.offset, got.last, got.status);
    endfunction

    function automatic stim_row_t row(input logic [2:0] op, input logic [31:0] v,
                                      input logic typed, input logic [7:0] b,
                                      input logic [15:0] off, input status_t st);
        return stim_row_t'{op, v, typed, serial_byte_t'{b, off, 1'b1, st}};
    endfunction

    always @(posedge clk)
    begin
        serial_byte_t got;
        serial_byte_t want;
        if (rst_n)
        begin
            if (cfg_we)
                model_cap = cfg_wdata;
            if (in_valid && in_ready)
            begin
                items_accepted++;
                fresh_q.delete();
                void'(encode_item(operation, value));
                if (cur_typed)
                    pending_q.push_back(cur_known);
                else
                    foreach (fresh_q[k])
                        pending_q.push_back(fresh_q[k]);
            end
            if (out_valid && out_ready)
            begin
                got = serial_byte_t'{out_byte, byte_offset, last, status_t'(status)};
                if (got.status == ST_BOUNDS)
                    bounds_seen++;
                if (got.status == ST_TOO_LARGE)
                    too_large_seen++;
                if (pending_q.size() == 0)
                    flag_mismatch("nothing pending", '0, got);
                else
                begin
                    want = pending_q.pop_front();
                    results_checked++;
                    if (got !== want)
                        flag_mismatch("field", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        if (hold_kick || hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    task automatic send_item(input logic [2:0] op, input logic [31:0] v, input logic typed,
                             input serial_byte_t known);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        cur_typed <= typed;
        cur_known <= known;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] cap, input int idle_pct, input int stall,
                             input int n_items, input bit hold);
        logic [2:0]  op;
        logic [31:0] v;
        int          sent;
        int          r;
        int          s;
        int          c;
        sent = 0;
        c = int'(cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we        <= 1'b0;
        out_stall_pct <= stall;
        in_idle_pct = idle_pct;
        capacity_writes++;
        if (hold)
            hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            v = $urandom;
            if (r < 4)
                op = (r < 2) ? OP_RESERVED_6 : OP_RESERVED_7;
            else if (r < 18)
            begin
                op = OP_SET_POS;
                if (s < 40)
                    v = c - $urandom_range(0, (c < 6) ? c : 6);
                else if (s < 55)
                    v = c + $urandom_range(1, 3);
                else if (s < 90)
                    v = $urandom_range(0, c);
            end
            else
            begin
                op = 3'($urandom_range(0, 4));
                if (op == OP_PACKED16)
                begin
                    if (s < 80)
                        v = v >> $urandom_range(17, 31);
                    else if (s < 90)
                        v = P16_LIMIT | ($urandom_range(0, 1) ? 32'h0000_7fff : 32'h0);
                end
                else if (op == OP_PACKED32)
                    v = v >> $urandom_range(0, 31);
            end
            send_item(op, v, 1'b0, '0);
            if (r >= 4)
                sent++;
        end
        drain();
    endtask

    initial
    begin
        stim_row_t rows [N_DIRECTED];
        rows = '{
            row(OP_SET_POS,    32'h0001_0000, 1'b1, 8'h00, 16'd0,     ST_BOUNDS),
            row(OP_BYTE,       32'h0000_01ff, 1'b1, 8'hff, 16'd0,     ST_OK),
            row(OP_BYTE,       32'h0000_0000, 1'b1, 8'h00, 16'd1,     ST_OK),
            row(OP_WORD16,     32'hffff_1234, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_WORD32,     32'hdead_beef, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_WORD32,     32'hffff_ffff, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED16,   32'h0000_007f, 1'b1, 8'h7f, 16'd12,    ST_OK),
            row(OP_PACKED16,   32'h0000_0080, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED16,   32'h0000_7fff, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED16,   32'h0000_8000, 1'b1, 8'h00, 16'd17,    ST_TOO_LARGE),
            row(OP_PACKED16,   32'hffff_ffff, 1'b1, 8'h00, 16'd17,    ST_TOO_LARGE),
            row(OP_PACKED32,   32'h0000_0000, 1'b1, 8'h00, 16'd17,    ST_OK),
            row(OP_PACKED32,   32'h0000_0080, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED32,   32'h0000_3fff, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED32,   32'h0000_4000, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED32,   32'h0fff_ffff, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_PACKED32,   32'hffff_ffff, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_RESERVED_6, 32'h5a5a_a5a5, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_RESERVED_7, 32'ha5a5_5a5a, 1'b0, 8'h00, 16'd0,     ST_OK),
            row(OP_SET_POS,    32'h0000_ffff, 1'b1, 8'h00, 16'hffff,  ST_OK),
            row(OP_BYTE,       32'h0000_005a, 1'b1, 8'h00, 16'hffff,  ST_BOUNDS),
            row(OP_PACKED16,   32'h0000_9000, 1'b1, 8'h00, 16'hffff,  ST_TOO_LARGE),
            row(OP_SET_POS,    32'h0000_fffe, 1'b1, 8'h00, 16'hfffe,  ST_OK),
            row(OP_BYTE,       32'h0000_00aa, 1'b1, 8'haa, 16'hfffe,  ST_OK),
            row(OP_WORD16,     32'h0000_1234, 1'b1, 8'h00, 16'hffff,  ST_BOUNDS),
            row(OP_SET_POS,    32'h0000_0000, 1'b1, 8'h00, 16'd0,     ST_OK)
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i].op, rows[i].value, rows[i].typed, rows[i].known);
        drain();
        run_phase(16'hffff, 0, 0, 50, 1'b0);
        run_phase(16'h0000, 74, 0, 20, 1'b0);
        run_phase(16'($urandom_range(1, 64)), 0, 74, 50, 1'b0);
        run_phase(16'($urandom_range(0, 65535)), 13, 13, 50, 1'b0);
        run_phase(16'($urandom_range(8, 48)), 0, 0, 40, 1'b1);
        run_phase(16'hffff, 0, 0, 50, 1'b0);
        $display("Run covered %0d transactions (%0d from the directed table), %0d result bytes",
                 items_accepted, N_DIRECTED, results_checked);
        $display("over %0d capacity settings; %0d out-of-bounds and %0d too-large statuses seen.",
                 capacity_writes, bounds_seen, too_large_seen);
        if (mismatch_count == 0 && pending_q.size() == 0)
            $display("bounded_message_serializer_top_tb: PASS");
        else
            $display("bounded_message_serializer_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("bounded_message_serializer_top_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bms_pkg.sv
rtl/core/bms_encoder.sv
rtl/core/bms_serializer.sv
rtl/core/bounded_message_serializer_top.sv
tb/sv/bounded_message_serializer_top_tb.sv
